/* src/epk_pkg.sv */
// Package for the RGB565 to e-paper pixel packer.
// Panel geometry, register codes, shared types, luma and Bayer threshold functions.
// No dependencies.
`default_nettype none

package epk_pkg;

  localparam int PANEL_WIDTH  = 960;
  localparam int PANEL_HEIGHT = 540;

  localparam int COORD_W = 12;
  localparam int IN_W    = 10;
  localparam int RGB_W   = 16;
  localparam int ADDR_W  = 18;
  localparam int PROD_W  = 24;
  localparam int CFG_W   = 2;
  localparam int IDX_W   = 2;

  localparam logic [COORD_W-1:0] PW = COORD_W'(PANEL_WIDTH);
  localparam logic [COORD_W-1:0] PH = COORD_W'(PANEL_HEIGHT);
  localparam logic [PROD_W-1:0] PITCH_GRAY = PROD_W'(PANEL_WIDTH / 2);
  localparam logic [PROD_W-1:0] PITCH_MONO = PROD_W'((PANEL_WIDTH + 7) / 8);

  localparam logic [IDX_W-1:0] REG_ROTATION = 2'd0;
  localparam logic [IDX_W-1:0] REG_MIRROR   = 2'd1;
  localparam logic [IDX_W-1:0] REG_GRAY     = 2'd2;
  localparam logic [IDX_W-1:0] REG_DITHER   = 2'd3;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam logic [7:0] MASK_HI_NIB = 8'hF0;
  localparam logic [7:0] MASK_LO_NIB = 8'h0F;
  localparam logic [7:0] MASK_MSB    = 8'h80;
  localparam logic [7:0] MONO_THRESH = 8'd128;

  typedef struct packed {
    logic [1:0] rotation_quadrant;
    logic [1:0] mirror_sel;
    logic       gray_4bpp;
    logic       dither_enable;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        write_mask;
    logic [7:0]        write_data;
  } res_t;

  function automatic logic [7:0] luma(input logic [RGB_W-1:0] rgb);
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [17:0] sum;
    r8  = {rgb[15:11], rgb[15:13]};
    g8  = {rgb[10:5], rgb[10:9]};
    b8  = {rgb[4:0], rgb[4:2]};
    sum = 18'(r8) * 18'd76 + 18'(g8) * 18'd150 + 18'(b8) * 18'd30;
    return sum[15:8];
  endfunction

  function automatic logic [3:0] bayer(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] v;
    case ({row, col})
      4'h0: v = 4'd0;   4'h1: v = 4'd8;  4'h2: v = 4'd2;  4'h3: v = 4'd10;
      4'h4: v = 4'd12;  4'h5: v = 4'd4;  4'h6: v = 4'd14; 4'h7: v = 4'd6;
      4'h8: v = 4'd3;   4'h9: v = 4'd11; 4'hA: v = 4'd1;  4'hB: v = 4'd9;
      4'hC: v = 4'd15;  4'hD: v = 4'd7;  4'hE: v = 4'd13; 4'hF: v = 4'd5;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/epk_xform.sv */
// Per-pixel datapath: bounds check, mirror, rotation, luma, pack into a byte write.
// Uses epk_pkg.
`default_nettype none

module epk_xform
  import epk_pkg::*;
(
  input  cfg_t              cfg,
  input  logic [IN_W-1:0]   screen_x,
  input  logic [IN_W-1:0]   screen_y,
  input  logic [RGB_W-1:0]  pixel_rgb565,
  output res_t              res
);

  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;
  logic [COORD_W-1:0] lw;
  logic [COORD_W-1:0] lh;
  logic [COORD_W-1:0] mx;
  logic [COORD_W-1:0] my;
  logic [COORD_W-1:0] px;
  logic [COORD_W-1:0] py;
  logic [7:0]         gray;
  logic [7:0]         thresh;
  logic [7:0]         mono_mask;
  logic               white;
  logic [PROD_W-1:0]  row_base;
  logic [ADDR_W-1:0]  col_byte;

  always_comb begin
    x  = COORD_W'(screen_x);
    y  = COORD_W'(screen_y);
    lw = cfg.rotation_quadrant[0] ? PH : PW;
    lh = cfg.rotation_quadrant[0] ? PW : PH;
    mx = cfg.mirror_sel[0] ? lw - 12'd1 - x : x;
    my = cfg.mirror_sel[1] ? lh - 12'd1 - y : y;

    case (cfg.rotation_quadrant)
      ROT_90: begin
        px = PW - 12'd1 - my;
        py = mx;
      end
      ROT_180: begin
        px = PW - 12'd1 - mx;
        py = PH - 12'd1 - my;
      end
      ROT_270: begin
        px = my;
        py = PH - 12'd1 - mx;
      end
      default: begin
        px = mx;
        py = my;
      end
    endcase

    // mirrored and rotated coordinates stay on the panel once the logical bounds hold
    res.hit = (x < lw) && (y < lh);

    gray      = luma(pixel_rgb565);
    thresh    = cfg.dither_enable ? {bayer(py[1:0], px[1:0]), 4'b0000} : MONO_THRESH;
    white     = gray >= thresh;
    mono_mask = MASK_MSB >> px[2:0];

    if (cfg.gray_4bpp) begin
      row_base = PROD_W'(py) * PITCH_GRAY;
      col_byte = ADDR_W'(px >> 1);
      if (!px[0]) begin
        res.write_mask = MASK_HI_NIB;
        res.write_data = {gray[7:4], 4'b0000};
      end else begin
        res.write_mask = MASK_LO_NIB;
        res.write_data = {4'b0000, gray[7:4]};
      end
    end else begin
      row_base = PROD_W'(py) * PITCH_MONO;
      col_byte = ADDR_W'(px >> 3);
      res.write_mask = mono_mask;
      res.write_data = white ? mono_mask : 8'h00;
    end
    res.byte_address = row_base[ADDR_W-1:0] + col_byte;
  end

endmodule

`default_nettype wire

/* src/rgb565_to_epaper_pixel_packer.sv */
// Top level of the pixel packer; uses epk_pkg and epk_xform.
// An accepted item passes through the input register, then the result register, to the
// outputs; throughput one item per cycle while out_ready is high.
// The input register holds only while the result register is full and out_ready is low.
// Pixels off the logical screen are dropped at the result register.
// Reset (rst, synchronous): both stages empty; 90 degrees, no mirror, mono, no dither.
`default_nettype none

module rgb565_to_epaper_pixel_packer
  import epk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   screen_x,
  input  logic [IN_W-1:0]   screen_y,
  input  logic [RGB_W-1:0]  pixel_rgb565,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] byte_address,
  output logic [7:0]        write_mask,
  output logic [7:0]        write_data
);

  cfg_t              cfg;
  logic              s1_valid;
  logic [IN_W-1:0]   s1_x;
  logic [IN_W-1:0]   s1_y;
  logic [RGB_W-1:0]  s1_rgb;
  logic              s2_free;
  res_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation_quadrant <= ROT_90;
      cfg.mirror_sel        <= 2'd0;
      cfg.gray_4bpp         <= 1'b0;
      cfg.dither_enable     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROTATION: cfg.rotation_quadrant <= cfg_data;
        REG_MIRROR:   cfg.mirror_sel        <= cfg_data;
        REG_GRAY:     cfg.gray_4bpp         <= cfg_data[0];
        REG_DITHER:   cfg.dither_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s2_free  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x   <= screen_x;
      s1_y   <= screen_y;
      s1_rgb <= pixel_rgb565;
    end
  end

  epk_xform u_xform (
    .cfg          (cfg),
    .screen_x     (s1_x),
    .screen_y     (s1_y),
    .pixel_rgb565 (s1_rgb),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid && res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid && res.hit) begin
      byte_address <= res.byte_address;
      write_mask   <= res.write_mask;
      write_data   <= res.write_data;
    end
  end

`ifndef ASSERT_OFF
  a_data_under_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((write_data & ~write_mask) == 8'h00))
    else $error("write data outside write mask");

  a_mask_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($onehot(write_mask) || write_mask == MASK_HI_NIB
                   || write_mask == MASK_LO_NIB))
    else $error("write mask is neither one bit nor one nibble");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> s1_valid)
    else $error("input stage lost an item during stall");
`endif

endmodule

`default_nettype wire
